// ----- hdl/lpmd_pkg.sv -----
// Shared types and constants for the length-prefixed message deframer.
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

  localparam int unsigned HDR_BYTES = 5;
  localparam logic [31:0] MAX_BYTES_RESET = 32'd4194304;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        is_compressed;
    logic        first_of_message;
    logic        last_of_message;
    logic [31:0] message_length;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/lpmd_parse.sv -----
// Header parser and message state for the deframer: one byte per cycle while accept is high.
`timescale 1ns / 1ps
`default_nettype none

module lpmd_parse
  import lpmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic [31:0] max_bytes,
  output logic             res_valid,
  output result_t          res
);

  localparam logic [31:0] HDR_LEN = 32'(HDR_BYTES);

  logic [31:0] bim_r, bim_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic        comp_r, comp_nxt;

  logic [32:0] next_cnt;
  logic [31:0] decl_shift;
  logic        over_limit;
  logic        last_byte;

  assign next_cnt   = {1'b0, bim_r} + 33'd1;
  assign over_limit = next_cnt > {1'b0, max_bytes};
  assign decl_shift = {decl_r[23:0], data_byte};
  // Payload bytes taken so far, including this one, equal the declared length.
  assign last_byte  = (bim_r - (HDR_LEN - 32'd1)) == decl_r;

  always_comb begin
    bim_nxt   = bim_r;
    decl_nxt  = decl_r;
    comp_nxt  = comp_r;
    res_valid = 1'b0;
    res       = '{kind: KIND_ERROR, payload_byte: 8'd0, is_compressed: 1'b0,
                  first_of_message: 1'b0, last_of_message: 1'b0,
                  message_length: 32'd0};
    if (accept) begin
      if (over_limit) begin
        bim_nxt   = 32'd0;
        decl_nxt  = 32'd0;
        comp_nxt  = 1'b0;
        res_valid = 1'b1;
      end else if (bim_r == 32'd0) begin
        comp_nxt = (data_byte != 8'd0);
        decl_nxt = 32'd0;
        bim_nxt  = 32'd1;
      end else if (bim_r < HDR_LEN) begin
        decl_nxt = decl_shift;
        bim_nxt  = next_cnt[31:0];
        if (bim_r == HDR_LEN - 32'd1) begin
          if (decl_shift > max_bytes) begin
            bim_nxt   = 32'd0;
            decl_nxt  = 32'd0;
            comp_nxt  = 1'b0;
            res_valid = 1'b1;
          end else if (decl_shift == 32'd0) begin
            res_valid           = 1'b1;
            res.kind            = KIND_EMPTY;
            res.is_compressed   = comp_r;
            res.last_of_message = 1'b1;
            bim_nxt             = 32'd0;
            decl_nxt            = 32'd0;
            comp_nxt            = 1'b0;
          end
        end
      end else begin
        res_valid            = 1'b1;
        res.kind             = KIND_PAYLOAD;
        res.payload_byte     = data_byte;
        res.is_compressed    = comp_r;
        res.first_of_message = (bim_r == HDR_LEN);
        res.last_of_message  = last_byte;
        res.message_length   = decl_r;
        if (last_byte) begin
          bim_nxt  = 32'd0;
          decl_nxt = 32'd0;
          comp_nxt = 1'b0;
        end else begin
          bim_nxt = next_cnt[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bim_r  <= 32'd0;
      decl_r <= 32'd0;
      comp_r <= 1'b0;
    end else begin
      bim_r  <= bim_nxt;
      decl_r <= decl_nxt;
      comp_r <= comp_nxt;
    end
  end

  a_error_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_ERROR) |=> (bim_r == 32'd0 && decl_r == 32'd0 && !comp_r))
    else $error("size error did not clear the message state");

  a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind == KIND_PAYLOAD) |-> (bim_r >= HDR_LEN && decl_r != 32'd0))
    else $error("payload byte emitted before a complete header");

  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !over_limit && bim_r < HDR_LEN - 32'd1) |-> !res_valid)
    else $error("result emitted for an early header byte");

endmodule

`default_nettype wire

// ----- hdl/length_prefixed_message_deframer.sv -----
// Top level of the length-prefixed message deframer with its output skid stage.
// Usage:
//   The input channel (in_valid, in_stall, in_data_byte) carries the framed byte
//   stream, one byte per transaction. Each message is a flag byte, a 32-bit
//   big-endian length and that many payload bytes.
//   The output channel (out_valid, out_stall, out_*) gives at most one result
//   per input byte: a payload byte with first/last marks, an empty-message
//   result, or a size error after which the next byte starts a new header.
//   The configuration channel (cfg_valid, cfg_ready, cfg_max_message_bytes)
//   sets the size limit; write it only while the block is idle.
// Timing:
//   One byte is accepted every cycle while in_stall is low. Each result is
//   registered in the output register, or in the skid register on a stall;
//   header parse and limit compares sit between input port and output register.
// Reset:
//   rst_n is synchronous; it clears the message state and output valids and
//   restores the limit to 4194304 bytes.
// Back-pressure:
//   A stalled result holds. A second result is caught in a skid register, and
//   in_stall rises only while that skid register is occupied.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_message_deframer
  import lpmd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_is_compressed,
  output logic             out_first_of_message,
  output logic             out_last_of_message,
  output logic [31:0]      out_message_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_message_bytes
);

  logic [31:0] max_r;
  logic        in_accept;
  logic        res_valid;
  result_t     res;
  logic        out_valid_r;
  result_t     out_r;
  logic        skid_valid_r;
  result_t     skid_r;
  logic        out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_r <= cfg_max_message_bytes;
    end
  end

  lpmd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .max_bytes (max_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      // While the skid register is full no byte is accepted, so it drains first.
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (res_valid) begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_r.kind;
  assign out_payload_byte     = out_r.payload_byte;
  assign out_is_compressed    = out_r.is_compressed;
  assign out_first_of_message = out_r.first_of_message;
  assign out_last_of_message  = out_r.last_of_message;
  assign out_message_length   = out_r.message_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register occupied while the output register is empty");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_EMPTY) |->
      (out_r.last_of_message && out_r.message_length == 32'd0))
    else $error("empty-message result with wrong fields");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && out_stall) |=> skid_valid_r)
    else $error("result arrived at a stalled output but was not held");

endmodule

`default_nettype wire
